@@ rtl/core/kle_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kle_pkg
// Shared types and constants of the keyframe rectangle evaluator.
// ----------------------------------------------------------------------------
package kle_pkg;

   // keyframe table size and derived widths
   localparam int MAX_KEYS    = 16;
   localparam int KEY_AW      = $clog2(MAX_KEYS);
   localparam int KEY_CW      = $clog2(MAX_KEYS + 1);

   // one table word: alpha, geometry, time
   localparam int TIME_W      = 32;
   localparam int GEO_W       = 64;
   localparam int ALPHA_W     = 8;
   localparam int KEY_WORD_W  = TIME_W + GEO_W + ALPHA_W;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   // request kinds
   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // classified request as it travels through the queue
   typedef struct packed {
      logic                kind;
      logic signed [32:0]  rel_time;
      logic [GEO_W-1:0]    geo;
      logic [ALPHA_W-1:0]  alpha;
   } kle_item_type;

endpackage : kle_pkg
`default_nettype wire

@@ rtl/core/kle_channels.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kle_channels
// Request and response channel interfaces of the keyframe evaluator.
// ----------------------------------------------------------------------------
interface kle_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [31:0]        time_value;
   logic signed [15:0] key_x;
   logic signed [15:0] key_y;
   logic signed [15:0] key_width;
   logic signed [15:0] key_height;
   logic [7:0]         key_alpha;

   modport source (output valid, req_type, time_value, key_x, key_y, key_width,
                   key_height, key_alpha, input ready);
   modport sink   (input valid, req_type, time_value, key_x, key_y, key_width,
                   key_height, key_alpha, output ready);
endinterface : kle_req_if

interface kle_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_x;
   logic signed [15:0] out_y;
   logic signed [15:0] out_width;
   logic signed [15:0] out_height;
   logic [7:0]         out_alpha;
   logic [1:0]         status;

   modport source (output valid, out_x, out_y, out_width, out_height, out_alpha,
                   status, input ready);
   modport sink   (input valid, out_x, out_y, out_width, out_height, out_alpha,
                   status, output ready);
endinterface : kle_rsp_if
`default_nettype wire

@@ rtl/core/kle_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kle_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule : kle_ram
`default_nettype wire

@@ rtl/core/kle_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kle_front
// Accepts requests, forms the scene-relative time and queues classified items.
// ----------------------------------------------------------------------------
module kle_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   kle_req_if.sink                   req_bus,
   input  wire logic                 csr_we,
   input  wire logic [31:0]          csr_wdata,
   output logic                      item_valid,
   output kle_pkg::kle_item_type     item,
   input  wire logic                 item_pop
);
   import kle_pkg::*;

   logic [31:0]        scene_start_ff;
   kle_item_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0] fill_ff, fill_in;
   logic               push;
   kle_item_type       new_item;

   // classify the incoming request; an add keeps its keyframe time as given
   always_comb begin
      new_item.kind     = req_bus.req_type;
      if (req_bus.req_type == REQ_ADD) begin
         new_item.rel_time = $signed({1'b0, req_bus.time_value});
      end else begin
         new_item.rel_time = $signed({1'b0, req_bus.time_value})
                           - $signed({1'b0, scene_start_ff});
      end
      new_item.geo      = {req_bus.key_height, req_bus.key_width,
                           req_bus.key_y, req_bus.key_x};
      new_item.alpha    = req_bus.key_alpha;
   end

   assign req_bus.ready = (fill_ff != QFILL_W'(QUEUE_DEPTH));
   assign push          = req_bus.valid && req_bus.ready;
   assign item_valid    = (fill_ff != '0);
   assign item          = slot_ff[rd_ptr_ff];

   // advance the queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (item_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !item_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && item_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   // hold control state and the scene start register
   always_ff @(posedge clock) begin
      if (reset) begin
         scene_start_ff <= '0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         fill_ff        <= '0;
      end else begin
         if (csr_we) begin
            scene_start_ff <= csr_wdata;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // store the request payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QFILL_W'(QUEUE_DEPTH))
      else $error("request queue overfilled");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("pop from empty request queue");

   a_fill_track: assert property (@(posedge clock) disable iff (reset)
      (push && !item_pop) |=> (fill_ff == $past(fill_ff) + 1'b1))
      else $error("queue fill count lost a request");

endmodule : kle_front
`default_nettype wire

@@ rtl/core/kle_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kle_back
// Carries out queued requests: keyframe table writes, segment search,
// serial fraction divide, shared-multiplier interpolation and result register.
// ----------------------------------------------------------------------------
module kle_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 item_valid,
   input  kle_pkg::kle_item_type     item,
   output logic                      item_pop,
   kle_rsp_if.source                 rsp_bus
);
   import kle_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_LAST_RD   = 9'b000000010,
      S_LAST_CHK  = 9'b000000100,
      S_FIRST_CHK = 9'b000001000,
      S_WALK_CHK  = 9'b000010000,
      S_DIV       = 9'b000100000,
      S_MUL       = 9'b001000000,
      S_ADD       = 9'b010000000,
      S_OUT       = 9'b100000000
   } state_type;

   localparam logic [2:0] LANE_ALPHA = 3'd4;

   state_type            state_ff, state_in;
   kle_item_type         item_ff, item_in;
   logic [KEY_CW-1:0]    count_ff, count_in;
   logic [GEO_W-1:0]     held_ff, held_in;
   logic [KEY_AW-1:0]    idx_ff, idx_in;
   logic [TIME_W-1:0]    prev_time_ff, prev_time_in;
   logic [GEO_W-1:0]     prev_geo_ff, prev_geo_in;
   logic [ALPHA_W-1:0]   prev_alpha_ff, prev_alpha_in;
   logic [GEO_W-1:0]     cur_geo_ff, cur_geo_in;
   logic [ALPHA_W-1:0]   cur_alpha_ff, cur_alpha_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          den_ff, den_in;
   logic [15:0]          quo_ff, quo_in;
   logic [3:0]           div_cnt_ff, div_cnt_in;
   logic [2:0]           lane_ff, lane_in;
   logic signed [33:0]   prod_ff, prod_in;
   logic [GEO_W-1:0]     res_geo_ff, res_geo_in;
   logic [ALPHA_W-1:0]   res_alpha_ff, res_alpha_in;
   logic [1:0]           res_status_ff, res_status_in;

   logic                 rsp_valid_ff;
   logic [GEO_W-1:0]     out_geo_ff;
   logic [ALPHA_W-1:0]   out_alpha_ff;
   logic [1:0]           out_status_ff;
   logic                 out_load;

   logic                 ram_we;
   logic [KEY_AW-1:0]    ram_waddr, ram_raddr;
   logic [KEY_WORD_W-1:0] ram_wdata, ram_rdata;
   logic [TIME_W-1:0]    rd_time;
   logic [GEO_W-1:0]     rd_geo;
   logic [ALPHA_W-1:0]   rd_alpha;
   logic [KEY_AW-1:0]    last_idx;
   logic signed [32:0]   t_rel;
   logic [32:0]          div_shift;
   logic signed [16:0]   lane_v0, lane_v1, lane_diff;
   logic signed [33:0]   prod_round;
   logic signed [17:0]   lane_step;
   logic signed [17:0]   lane_sum;

   kle_ram #(.WIDTH(KEY_WORD_W), .DEPTH(MAX_KEYS)) u_key_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_time   = ram_rdata[TIME_W-1:0];
   assign rd_geo    = ram_rdata[TIME_W +: GEO_W];
   assign rd_alpha  = ram_rdata[TIME_W + GEO_W +: ALPHA_W];
   assign last_idx  = KEY_AW'(count_ff - 1'b1);
   assign t_rel     = item_ff.rel_time;
   assign ram_waddr = count_ff[KEY_AW-1:0];
   assign ram_wdata = {item.alpha, item.geo, item.rel_time[TIME_W-1:0]};
   assign div_shift = {rem_ff, 1'b0};

   // select the lane being interpolated
   always_comb begin
      if (lane_ff == LANE_ALPHA) begin
         lane_v0 = $signed({9'b0, prev_alpha_ff});
         lane_v1 = $signed({9'b0, cur_alpha_ff});
      end else begin
         lane_v0 = 17'(signed'(prev_geo_ff[16*lane_ff[1:0] +: 16]));
         lane_v1 = 17'(signed'(cur_geo_ff[16*lane_ff[1:0] +: 16]));
      end
      lane_diff  = lane_v1 - lane_v0;
      prod_round = prod_ff + 34'sd32768;
      lane_step  = prod_round[33:16];
      lane_sum   = $signed({lane_v0[16], lane_v0}) + lane_step;
   end

   // sequence one request at a time
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      count_in      = count_ff;
      held_in       = held_ff;
      idx_in        = idx_ff;
      prev_time_in  = prev_time_ff;
      prev_geo_in   = prev_geo_ff;
      prev_alpha_in = prev_alpha_ff;
      cur_geo_in    = cur_geo_ff;
      cur_alpha_in  = cur_alpha_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      lane_in       = lane_ff;
      prod_in       = prod_ff;
      res_geo_in    = res_geo_ff;
      res_alpha_in  = res_alpha_ff;
      res_status_in = res_status_ff;
      item_pop      = 1'b0;
      ram_we        = 1'b0;
      ram_raddr     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               item_pop      = 1'b1;
               item_in       = item;
               res_geo_in    = '0;
               res_alpha_in  = '0;
               res_status_in = STATUS_OK;
               if (item.kind == REQ_ADD) begin
                  if (count_ff >= KEY_CW'(MAX_KEYS)) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     ram_we   = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
                  state_in = S_OUT;
               end else if (count_ff == '0) begin
                  res_geo_in    = held_ff;
                  res_status_in = STATUS_EMPTY;
                  state_in      = S_OUT;
               end else begin
                  state_in = S_LAST_RD;
               end
            end
         end
         S_LAST_RD: begin
            ram_raddr = last_idx;
            state_in  = S_LAST_CHK;
         end
         S_LAST_CHK: begin
            // clamp at or after the last keyframe
            if (t_rel >= $signed({1'b0, rd_time})) begin
               res_geo_in   = rd_geo;
               res_alpha_in = rd_alpha;
               held_in      = rd_geo;
               state_in     = S_OUT;
            end else begin
               state_in = S_FIRST_CHK;
            end
         end
         S_FIRST_CHK: begin
            ram_raddr = KEY_AW'(1);
            // clamp before the first keyframe
            if (t_rel < $signed({1'b0, rd_time})) begin
               res_geo_in   = rd_geo;
               res_alpha_in = rd_alpha;
               held_in      = rd_geo;
               state_in     = S_OUT;
            end else begin
               prev_time_in  = rd_time;
               prev_geo_in   = rd_geo;
               prev_alpha_in = rd_alpha;
               idx_in        = KEY_AW'(1);
               state_in      = S_WALK_CHK;
            end
         end
         S_WALK_CHK: begin
            ram_raddr = idx_ff + 1'b1;
            if (t_rel >= $signed({1'b0, prev_time_ff})
                && t_rel < $signed({1'b0, rd_time})) begin
               cur_geo_in   = rd_geo;
               cur_alpha_in = rd_alpha;
               rem_in       = t_rel[31:0] - prev_time_ff;
               den_in       = rd_time - prev_time_ff;
               quo_in       = '0;
               div_cnt_in   = '0;
               state_in     = S_DIV;
            end else if (idx_ff == last_idx) begin
               // no enclosing segment: repeat the held rectangle
               res_geo_in = held_ff;
               state_in   = S_OUT;
            end else begin
               prev_time_in  = rd_time;
               prev_geo_in   = rd_geo;
               prev_alpha_in = rd_alpha;
               idx_in        = idx_ff + 1'b1;
            end
         end
         S_DIV: begin
            // one quotient bit per cycle
            if (div_shift >= {1'b0, den_ff}) begin
               rem_in = 32'(div_shift - {1'b0, den_ff});
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = div_shift[31:0];
               quo_in = {quo_ff[14:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == 4'd15) begin
               lane_in  = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = lane_diff * $signed({1'b0, quo_ff});
            state_in = S_ADD;
         end
         S_ADD: begin
            if (lane_ff == LANE_ALPHA) begin
               res_alpha_in = lane_sum[ALPHA_W-1:0];
               held_in      = res_geo_ff;
               state_in     = S_OUT;
            end else begin
               res_geo_in[16*lane_ff[1:0] +: 16] = lane_sum[15:0];
               lane_in  = lane_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         held_ff  <= held_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold working payload
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      idx_ff        <= idx_in;
      prev_time_ff  <= prev_time_in;
      prev_geo_ff   <= prev_geo_in;
      prev_alpha_ff <= prev_alpha_in;
      cur_geo_ff    <= cur_geo_in;
      cur_alpha_ff  <= cur_alpha_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      quo_ff        <= quo_in;
      div_cnt_ff    <= div_cnt_in;
      lane_ff       <= lane_in;
      prod_ff       <= prod_in;
      res_geo_ff    <= res_geo_in;
      res_alpha_ff  <= res_alpha_in;
      res_status_ff <= res_status_in;
      if (out_load) begin
         out_geo_ff    <= res_geo_ff;
         out_alpha_ff  <= res_alpha_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_x      = out_geo_ff[15:0];
   assign rsp_bus.out_y      = out_geo_ff[31:16];
   assign rsp_bus.out_width  = out_geo_ff[47:32];
   assign rsp_bus.out_height = out_geo_ff[63:48];
   assign rsp_bus.out_alpha  = out_alpha_ff;
   assign rsp_bus.status     = out_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= KEY_CW'(MAX_KEYS))
      else $error("keyframe count beyond table size");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> (state_ff == S_IDLE))
      else $error("request taken while busy");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder out of range");

   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("finished result not presented");

endmodule : kle_back
`default_nettype wire

@@ rtl/core/keyframe_lerp_evaluator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keyframe_lerp_evaluator
// Keyframe table with clamped piecewise linear rectangle evaluation.
// ----------------------------------------------------------------------------
// A request either appends a keyframe or evaluates the rectangle at an
// absolute tick less the scene start register. Requests pass through a
// two-entry queue to a sequencer that handles one at a time, so a new
// request is taken while a result waits on the response channel. A query
// that interpolates takes the longest path: the segment search reads one
// keyframe per cycle through the single read port of the keyframe RAM, the
// fraction comes from a radix-2 divider, and five values share one
// multiplier, each with a multiply step and an add step.
// ----------------------------------------------------------------------------
module keyframe_lerp_evaluator (
   input  wire logic        clock,
   input  wire logic        reset,
   kle_req_if.sink          req_bus,
   kle_rsp_if.source        rsp_bus,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata
);
   import kle_pkg::*;

   logic         item_valid;
   logic         item_pop;
   kle_item_type item;

   kle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   kle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_bus    (rsp_bus)
   );

endmodule : keyframe_lerp_evaluator
`default_nettype wire

@@ test/kle_channels_tb.sv @@
// ----------------------------------------------------------------------------
// kle_channels_tb
// Testbench-side helper types for the keyframe evaluator channels.
// ----------------------------------------------------------------------------
package kle_tb_pkg;

   // one expected rectangle result
   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] w;
      logic signed [15:0] h;
      logic [7:0]         alpha;
      logic [1:0]         status;
   } rect_result_type;

endpackage : kle_tb_pkg

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyframe rectangle evaluator.
// ----------------------------------------------------------------------------
// Adds keyframes and queries rectangles through the request channel, predicts
// every result with an independent keyframe model and compares each response
// field by field. Covers clamping at both ends, interpolation, empty and full
// tables, out-of-order tables and several scene start settings, with random
// idling on both channels and one long response stall.
// ----------------------------------------------------------------------------
module testbench;
   import kle_pkg::*;
   import kle_tb_pkg::*;

   // keyframe predictor and expected results
   class rect_scoreboard;
      logic [31:0]        scene_start;
      logic [31:0]        key_time [MAX_KEYS];
      logic signed [15:0] key_geo  [MAX_KEYS][4];
      logic [7:0]         key_alf  [MAX_KEYS];
      int                 key_count;
      logic signed [15:0] held [4];
      rect_result_type    pending [$];
      int                 errors;

      function new();
         scene_start = 0;
         key_count   = 0;
         errors      = 0;
         foreach (held[k]) held[k] = 0;
      endfunction

      // print one mismatch line and count it
      task report(string msg);
         errors++;
         $display("ERROR: %s", msg);
      endtask

      // round-to-nearest lerp between two values at fraction f
      function automatic longint blend(longint a, longint b, longint f);
         longint prod;
         prod = (b - a) * f + 32768;
         return a + (prod >>> 16);
      endfunction

      // note one accepted request and queue its expected result
      function void note_request(logic kind, logic [31:0] tv, logic signed [15:0] g [4],
                                 logic [7:0] alf);
         rect_result_type r;
         longint t, t0, t1, f;
         int last;
         bit found;
         r = '{0, 0, 0, 0, 0, STATUS_OK};
         if (kind == REQ_ADD) begin
            if (key_count >= MAX_KEYS) begin
               r.status = STATUS_FULL;
            end else begin
               key_time[key_count] = tv;
               foreach (g[k]) key_geo[key_count][k] = g[k];
               key_alf[key_count] = alf;
               key_count++;
            end
         end else if (key_count == 0) begin
            r.x = held[0]; r.y = held[1]; r.w = held[2]; r.h = held[3];
            r.status = STATUS_EMPTY;
         end else begin
            t = longint'(tv) - longint'(scene_start);
            last = key_count - 1;
            found = 1;
            if (t >= longint'(key_time[last])) begin
               foreach (held[k]) held[k] = key_geo[last][k];
               r.alpha = key_alf[last];
            end else if (t < longint'(key_time[0])) begin
               foreach (held[k]) held[k] = key_geo[0][k];
               r.alpha = key_alf[0];
            end else begin
               found = 0;
               for (int i = 0; i < last && !found; i++) begin
                  t0 = key_time[i];
                  t1 = key_time[i + 1];
                  if (t >= t0 && t < t1) begin
                     found = 1;
                     f = ((t - t0) << 16) / (t1 - t0);
                     foreach (held[k])
                        held[k] = 16'(blend(key_geo[i][k], key_geo[i + 1][k], f));
                     r.alpha = 8'(blend(key_alf[i], key_alf[i + 1], f));
                  end
               end
            end
            r.x = held[0]; r.y = held[1]; r.w = held[2]; r.h = held[3];
         end
         pending.insert(pending.size(), r);
      endfunction

      // compare one response with the oldest expectation
      task check_response(rect_result_type got);
         rect_result_type e;
         if (pending.size() == 0) begin
            report("response with nothing expected");
            return;
         end
         e = pending.pop_front();
         if (got.x !== e.x || got.y !== e.y || got.w !== e.w || got.h !== e.h ||
             got.alpha !== e.alpha || got.status !== e.status) begin
            report($sformatf("got %0d %0d %0d %0d a%0d s%0d, expected %0d %0d %0d %0d a%0d s%0d",
                             got.x, got.y, got.w, got.h, got.alpha, got.status,
                             e.x, e.y, e.w, e.h, e.alpha, e.status));
         end
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [31:0] csr_wdata = 0;
   int send_idle = 0;
   int recv_idle = 0;
   bit long_stall = 0;
   rect_scoreboard board;

   kle_req_if req_bus ();
   kle_rsp_if rsp_bus ();

   keyframe_lerp_evaluator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus.sink),
      .rsp_bus   (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // generous limit for the whole run
   initial begin
      #20000000;
      $display("simulation failed");
      $finish;
   end

   // receiver: random ready, checked at the rising edge
   initial begin
      rsp_bus.ready = 0;
      forever begin
         @(negedge clock);
         if (long_stall) begin
            rsp_bus.ready <= 0;
            repeat (300) @(negedge clock);
            long_stall = 0;
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      rect_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.out_x, rsp_bus.out_y, rsp_bus.out_width, rsp_bus.out_height,
                 rsp_bus.out_alpha, rsp_bus.status};
         board.check_response(got);
      end
   end

   // offer one request and hold it until accepted
   task automatic send_request(logic kind, logic [31:0] tv, logic signed [15:0] x,
                               logic signed [15:0] y, logic signed [15:0] w,
                               logic signed [15:0] h, logic [7:0] alf);
      logic signed [15:0] g [4];
      g = '{x, y, w, h};
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 0;
         @(negedge clock);
      end
      req_bus.valid      <= 1;
      req_bus.req_type   <= kind;
      req_bus.time_value <= tv;
      req_bus.key_x      <= x;
      req_bus.key_y      <= y;
      req_bus.key_width  <= w;
      req_bus.key_height <= h;
      req_bus.key_alpha  <= alf;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(kind, tv, g, alf);
      @(negedge clock);
   endtask

   task automatic add_random_key(logic [31:0] tv);
      send_request(REQ_ADD, tv, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 8'($urandom));
   endtask

   task automatic query_at(logic [31:0] tv);
      send_request(REQ_QUERY, tv, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 8'($urandom));
   endtask

   // wait for every result, then let the block settle and write scene start
   task automatic drain_and_set_start(logic [31:0] value);
      req_bus.valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      csr_we    <= 1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 0;
      board.scene_start = value;
   endtask

   // the table clears only through reset, which is never raised again, so the
   // model table fills once and stays; random phases vary queries over it
   initial begin
      int waited;
      logic [31:0] base, t;
      board = new();
      req_bus.valid = 0;
      req_bus.req_type = REQ_ADD;
      req_bus.time_value = 0;
      req_bus.key_x = 0;
      req_bus.key_y = 0;
      req_bus.key_width = 0;
      req_bus.key_height = 0;
      req_bus.key_alpha = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: empty table, extremes and special cases
      send_idle = 32; recv_idle = 51;
      query_at(0);
      query_at(32'hFFFF_FFFF);
      send_request(REQ_ADD, 100, 16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 8'hFF);
      query_at(100);
      query_at(5);
      query_at(32'hFFFF_FFFF);
      send_request(REQ_ADD, 200, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 8'h00);
      query_at(150);
      query_at(199);
      query_at(101);
      query_at(200);
      send_request(REQ_ADD, 32'h7FFF_0000, 16'sh0010, 16'sh0020, 16'sh0030, 16'sh0040, 8'h80);
      query_at(32'h4000_0000);
      query_at(32'h7FFE_FFFF);
      drain_and_set_start(32'hFFFF_FFFF);
      query_at(0);
      query_at(150);
      query_at(32'hFFFF_FFFF);
      drain_and_set_start(32'd50);
      query_at(200);
      // out-of-order key: no segment for some times
      send_request(REQ_ADD, 32'd10, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 8'd5);
      query_at(250);
      query_at(60);
      query_at(32'h7FFF_0060);

      // random: mostly queries, with occasional adds at mostly rising times
      base = 32'h7FFF_1000;
      for (int n = 0; n < 1150; n++) begin
         if (n == 380) begin
            drain_and_set_start($urandom);
            send_idle = 51; recv_idle = 32;
         end
         if (n == 760) begin
            drain_and_set_start(32'd0);
            send_idle = 0; recv_idle = 0;
            long_stall = 1;
         end
         if ($urandom_range(99) < 8) begin
            base = base + $urandom_range(1, 4000);
            add_random_key(($urandom_range(3) == 0) ? $urandom : base);
         end else begin
            case ($urandom_range(3))
               0: t = $urandom;
               1: t = board.scene_start + $urandom_range(32'h7FFF_0000, 32'h7FFF_8000);
               2: t = board.scene_start + base + $urandom_range(0, 200) - 100;
               default: t = board.scene_start + 32'h7FFF_0000 + $urandom_range(0, 8000);
            endcase
            query_at(t);
         end
      end

      // wait for the tail, with a limit
      req_bus.valid <= 0;
      waited = 0;
      while (board.pending.size() != 0 && waited < 100000) begin
         @(negedge clock);
         waited++;
      end
      repeat (60) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule : testbench

@@ filelist.f @@
rtl/core/kle_pkg.sv
rtl/core/kle_channels.sv
rtl/core/kle_ram.sv
rtl/core/kle_front.sv
rtl/core/kle_back.sv
rtl/core/keyframe_lerp_evaluator.sv
test/kle_channels_tb.sv
test/testbench.sv
